@@ design/mbd_pkg.sv @@
// Shared constants and types for the microphone blow detector.
package mbd_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int EMA_SHIFT = 7;
  localparam int TIME_BITS = 32;
  localparam int GAP_BITS = 16;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS = 16;

  typedef enum logic [1:0] {
    KIND_SAMPLE  = 2'd0,
    KIND_CLEAR   = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_UNUSED  = 2'd3
  } kind_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_LOUD_THRESHOLD = 2'd0,
    CFG_QUIET_GAP_MS   = 2'd1,
    CFG_DWELL_MS       = 2'd2,
    CFG_RESERVED       = 2'd3
  } cfg_index_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] dc_estimate;
    logic                   dc_seeded;
    logic [SAMPLE_BITS-1:0] envelope_level;
    logic [TIME_BITS-1:0]   last_loud_time;
    logic [TIME_BITS-1:0]   streak_start_time;
    logic                   streak_on;
  } state_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] dc_level;
    logic [SAMPLE_BITS-1:0] deviation;
    logic [SAMPLE_BITS-1:0] envelope;
    logic                   streak_active;
    logic                   blow_detected;
  } result_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] loud_threshold;
    logic [GAP_BITS-1:0]    quiet_gap_ms;
    logic [GAP_BITS-1:0]    dwell_ms;
  } cfg_t;

endpackage

@@ design/mbd_update.sv @@
// Per-item update logic: DC tracking, envelope and loud-streak detection.
module mbd_update (
  input  logic [1:0]                     kind,
  input  logic [mbd_pkg::SAMPLE_BITS-1:0] sample,
  input  logic [mbd_pkg::TIME_BITS-1:0]   now_ms,
  input  mbd_pkg::cfg_t                   cfg,
  input  mbd_pkg::state_t                 state_cur,
  output mbd_pkg::state_t                 state_next,
  output mbd_pkg::result_t                result
);

  logic signed [mbd_pkg::SAMPLE_BITS:0]   diff;
  logic signed [mbd_pkg::SAMPLE_BITS:0]   step;
  logic [mbd_pkg::SAMPLE_BITS-1:0]        dc_new;
  logic [mbd_pkg::SAMPLE_BITS-1:0]        dev;
  logic [mbd_pkg::SAMPLE_BITS-1:0]        env_new;
  logic [mbd_pkg::TIME_BITS-1:0]          quiet_time;
  logic [mbd_pkg::TIME_BITS-1:0]          streak_age;
  logic                                   loud;
  logic                                   gap_over;

  assign diff = $signed({1'b0, sample}) - $signed({1'b0, state_cur.dc_estimate});
  assign step = diff >>> mbd_pkg::EMA_SHIFT;
  assign dc_new = state_cur.dc_seeded ?
                  (state_cur.dc_estimate + step[mbd_pkg::SAMPLE_BITS-1:0]) : sample;
  assign dev = (sample >= dc_new) ? (sample - dc_new) : (dc_new - sample);
  assign env_new = (dev > state_cur.envelope_level) ? dev :
                   ((state_cur.envelope_level != '0) ?
                    (state_cur.envelope_level - 1'b1) : state_cur.envelope_level);
  assign loud = (dev >= cfg.loud_threshold);
  assign quiet_time = now_ms - state_cur.last_loud_time;
  assign gap_over = (quiet_time > {{(mbd_pkg::TIME_BITS-mbd_pkg::GAP_BITS){1'b0}},
                                   cfg.quiet_gap_ms});

  always_comb begin
    state_next = state_cur;
    case (mbd_pkg::kind_t'(kind))
      mbd_pkg::KIND_SAMPLE: begin
        state_next.dc_estimate = dc_new;
        state_next.dc_seeded = 1'b1;
        state_next.envelope_level = env_new;
        if (loud) begin
          if (!state_cur.streak_on) begin
            state_next.streak_on = 1'b1;
            state_next.streak_start_time = now_ms;
          end
          state_next.last_loud_time = now_ms;
        end else if (state_cur.streak_on && gap_over) begin
          state_next.streak_on = 1'b0;
        end
      end
      mbd_pkg::KIND_CLEAR: begin
        state_next.streak_on = 1'b0;
      end
      mbd_pkg::KIND_RESTART: begin
        state_next.dc_seeded = 1'b0;
        state_next.dc_estimate = '0;
        state_next.envelope_level = '0;
        state_next.streak_on = 1'b0;
      end
      default: begin
        state_next = state_cur;
      end
    endcase
  end

  assign streak_age = now_ms - state_next.streak_start_time;

  always_comb begin
    result.dc_level = state_next.dc_estimate;
    result.deviation = (mbd_pkg::kind_t'(kind) == mbd_pkg::KIND_SAMPLE) ? dev : '0;
    result.envelope = state_next.envelope_level;
    result.streak_active = state_next.streak_on;
    result.blow_detected = state_next.streak_on &&
        (streak_age >= {{(mbd_pkg::TIME_BITS-mbd_pkg::GAP_BITS){1'b0}}, cfg.dwell_ms});
  end

endmodule

@@ design/mic_blow_detector_unit.sv @@
// Top level of the microphone blow detector with handshake and register port.
//
// The block accepts one item per clock cycle while its results are taken,
// and sustains that rate under continuous flow. An accepted item is held
// in an input register; its whole update (DC average, deviation, envelope
// and streak timing) is computed combinationally from it and captured in
// the result register, which offers it, when the output can advance. The
// tracker state is updated in that same cycle, so the next item uses it.
// When the result is not taken, the input register holds one more item and
// then the block stops accepting. Configuration writes take effect on the
// next clock edge and are meant to be made while no item is in flight.
module mic_blow_detector_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          kind,
  input  logic [mbd_pkg::SAMPLE_BITS-1:0]     sample,
  input  logic [mbd_pkg::TIME_BITS-1:0]       now_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [mbd_pkg::SAMPLE_BITS-1:0]     dc_level,
  output logic [mbd_pkg::SAMPLE_BITS-1:0]     deviation,
  output logic [mbd_pkg::SAMPLE_BITS-1:0]     envelope,
  output logic                                streak_active,
  output logic                                blow_detected,
  input  logic                                cfg_we,
  input  logic [mbd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [mbd_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

  mbd_pkg::cfg_t                   cfg;
  mbd_pkg::state_t                 state;
  mbd_pkg::state_t                 state_next;
  mbd_pkg::result_t                result_next;
  mbd_pkg::result_t                result;
  logic                            hold_valid;
  logic [1:0]                      hold_kind;
  logic [mbd_pkg::SAMPLE_BITS-1:0] hold_sample;
  logic [mbd_pkg::TIME_BITS-1:0]   hold_now_ms;
  logic                            advance;

  assign advance = hold_valid && (!out_valid || out_ready);
  assign in_ready = !hold_valid || advance;

  mbd_update u_update (
    .kind       (hold_kind),
    .sample     (hold_sample),
    .now_ms     (hold_now_ms),
    .cfg        (cfg),
    .state_cur  (state),
    .state_next (state_next),
    .result     (result_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.loud_threshold <= mbd_pkg::SAMPLE_BITS'(64);
      cfg.quiet_gap_ms <= mbd_pkg::GAP_BITS'(50);
      cfg.dwell_ms <= mbd_pkg::GAP_BITS'(300);
    end else if (cfg_we) begin
      case (mbd_pkg::cfg_index_t'(cfg_index))
        mbd_pkg::CFG_LOUD_THRESHOLD: cfg.loud_threshold <= cfg_data[mbd_pkg::SAMPLE_BITS-1:0];
        mbd_pkg::CFG_QUIET_GAP_MS: cfg.quiet_gap_ms <= cfg_data;
        mbd_pkg::CFG_DWELL_MS: cfg.dwell_ms <= cfg_data;
        default: cfg <= cfg;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
      out_valid <= 1'b0;
      state <= '0;
    end else begin
      if (in_ready) begin
        hold_valid <= in_valid;
      end
      if (advance) begin
        out_valid <= 1'b1;
        state <= state_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_kind <= kind;
      hold_sample <= sample;
      hold_now_ms <= now_ms;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  assign dc_level = result.dc_level;
  assign deviation = result.deviation;
  assign envelope = result.envelope;
  assign streak_active = result.streak_active;
  assign blow_detected = result.blow_detected;

endmodule

@@ dv/tb_mic_blow_detector_unit.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the microphone blow detector unit.
module tb_mic_blow_detector_unit;
  import mbd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    kind_t                  kind;
    logic [SAMPLE_BITS-1:0] sample;
    logic [TIME_BITS-1:0]   now_ms;
  } mic_item_t;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_ready;
  logic [1:0]                kind;
  logic [SAMPLE_BITS-1:0]    sample;
  logic [TIME_BITS-1:0]      now_ms;
  logic                      out_valid;
  logic                      out_ready;
  logic [SAMPLE_BITS-1:0]    dc_level;
  logic [SAMPLE_BITS-1:0]    deviation;
  logic [SAMPLE_BITS-1:0]    envelope;
  logic                      streak_active;
  logic                      blow_detected;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;

  mic_item_t pending_items[$];
  result_t   expected_results[$];
  int        mismatch_count = 0;
  int        cycle_count = 0;
  logic      no_idle = 1'b0;

  cfg_t det_cfg = '{loud_threshold: 10'd64, quiet_gap_ms: 16'd50, dwell_ms: 16'd300};
  logic [SAMPLE_BITS-1:0] est_dc = '0;
  logic                   est_seeded = 1'b0;
  logic [SAMPLE_BITS-1:0] est_env = '0;
  logic [TIME_BITS-1:0]   est_last_loud = '0;
  logic [TIME_BITS-1:0]   est_streak_start = '0;
  logic                   est_streak_on = 1'b0;

  logic [TIME_BITS-1:0] sim_ms = '0;
  int                   mic_bias = 512;
  logic                 burst_on = 1'b0;

  mic_blow_detector_unit u_top (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .sample        (sample),
    .now_ms        (now_ms),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .dc_level      (dc_level),
    .deviation     (deviation),
    .envelope      (envelope),
    .streak_active (streak_active),
    .blow_detected (blow_detected),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic result_t predict_result(input kind_t k, input logic [SAMPLE_BITS-1:0] x,
                                             input logic [TIME_BITS-1:0] t);
    result_t                r;
    int                     step;
    logic [SAMPLE_BITS-1:0] dev;
    dev = '0;
    case (k)
      KIND_SAMPLE: begin
        if (!est_seeded) begin
          est_dc = x;
          est_seeded = 1'b1;
        end else begin
          step = (int'(x) - int'(est_dc)) >>> EMA_SHIFT;
          est_dc = SAMPLE_BITS'(int'(est_dc) + step);
        end
        dev = (x >= est_dc) ? x - est_dc : est_dc - x;
        if (dev > est_env) begin
          est_env = dev;
        end else if (est_env != '0) begin
          est_env = est_env - 1'b1;
        end
        if (dev >= det_cfg.loud_threshold) begin
          if (!est_streak_on) begin
            est_streak_on = 1'b1;
            est_streak_start = t;
          end
          est_last_loud = t;
        end else if (est_streak_on && (t - est_last_loud) > det_cfg.quiet_gap_ms) begin
          est_streak_on = 1'b0;
        end
      end
      KIND_CLEAR: begin
        est_streak_on = 1'b0;
      end
      KIND_RESTART: begin
        est_seeded = 1'b0;
        est_dc = '0;
        est_env = '0;
        est_streak_on = 1'b0;
      end
      default: begin
      end
    endcase
    r.dc_level = est_dc;
    r.deviation = dev;
    r.envelope = est_env;
    r.streak_active = est_streak_on;
    r.blow_detected = est_streak_on && ((t - est_streak_start) >= det_cfg.dwell_ms);
    return r;
  endfunction

  // Sender: the accepted item is predicted at the edge that takes it.
  always @(posedge clk) begin : drive_proc
    mic_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_results.push_back(predict_result(kind_t'(kind), sample, now_ms));
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && (no_idle || $urandom_range(99) >= 30)) begin
          nxt = pending_items.pop_front();
          in_valid <= 1'b1;
          kind <= nxt.kind;
          sample <= nxt.sample;
          now_ms <= nxt.now_ms;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_proc
    result_t got;
    result_t want;
    if (!rst && out_valid && out_ready) begin
      got = {dc_level, deviation, envelope, streak_active, blow_detected};
      if (expected_results.size() == 0) begin
        if (mismatch_count < 10) begin
          $display("%0t: result with no item pending: dc %0d dev %0d env %0d streak %0d blow %0d",
                   $realtime, got.dc_level, got.deviation, got.envelope,
                   got.streak_active, got.blow_detected);
        end
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (got.dc_level !== want.dc_level || got.deviation !== want.deviation ||
            got.envelope !== want.envelope || got.streak_active !== want.streak_active ||
            got.blow_detected !== want.blow_detected) begin
          if (mismatch_count < 10) begin
            $display("%0t: mismatch exp dc %0d dev %0d env %0d streak %0d blow %0d",
                     $realtime, want.dc_level, want.deviation, want.envelope,
                     want.streak_active, want.blow_detected);
            $display("%0t:          got dc %0d dev %0d env %0d streak %0d blow %0d",
                     $realtime, got.dc_level, got.deviation, got.envelope,
                     got.streak_active, got.blow_detected);
          end
          mismatch_count++;
        end
      end
    end
    out_ready <= no_idle || ($urandom_range(99) >= 30);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_item(input kind_t k, input logic [SAMPLE_BITS-1:0] x,
                           input logic [TIME_BITS-1:0] t);
    mic_item_t it;
    it.kind = k;
    it.sample = x;
    it.now_ms = t;
    pending_items.push_back(it);
  endtask

  // Well-formed traffic: time mostly creeps forward, the signal sits on a bias
  // with quiet noise or loud bursts, and now and then a control item.
  task automatic queue_activity(input int count);
    int   roll;
    int   level;
    kind_t k;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 3) begin
        sim_ms = $urandom;
      end else if (roll < 5) begin
        sim_ms = 32'hFFFF_FFFF - $urandom_range(40);
      end else if (roll < 9) begin
        sim_ms = sim_ms + $urandom_range(2000);
      end else begin
        sim_ms = sim_ms + $urandom_range(12);
      end
      if ($urandom_range(99) < 8) begin
        burst_on = !burst_on;
      end
      if ($urandom_range(199) == 0) begin
        mic_bias = $urandom_range(1023);
      end
      roll = $urandom_range(99);
      if (roll < 4) begin
        k = KIND_CLEAR;
      end else if (roll < 7) begin
        k = KIND_RESTART;
      end else if (roll < 9) begin
        k = KIND_UNUSED;
      end else begin
        k = KIND_SAMPLE;
      end
      if ($urandom_range(99) < 10) begin
        level = $urandom_range(1023);
      end else if (burst_on) begin
        level = mic_bias + int'($urandom_range(700)) - 350;
      end else begin
        level = mic_bias + int'($urandom_range(16)) - 8;
      end
      if (level < 0) begin
        level = 0;
      end else if (level > 1023) begin
        level = 1023;
      end
      push_item(k, SAMPLE_BITS'(level), sim_ms);
    end
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      CFG_LOUD_THRESHOLD: det_cfg.loud_threshold = value[SAMPLE_BITS-1:0];
      CFG_QUIET_GAP_MS:   det_cfg.quiet_gap_ms = value;
      CFG_DWELL_MS:       det_cfg.dwell_ms = value;
      default: begin
      end
    endcase
  endtask

  task automatic set_config(input logic [CFG_DATA_BITS-1:0] thr_word,
                            input logic [CFG_DATA_BITS-1:0] gap,
                            input logic [CFG_DATA_BITS-1:0] dwell);
    write_reg(CFG_LOUD_THRESHOLD, thr_word);
    write_reg(CFG_QUIET_GAP_MS, gap);
    write_reg(CFG_DWELL_MS, dwell);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every item is sent and every result has come back.
  task automatic wait_drained();
    do begin
      @(posedge clk);
    end while (pending_items.size() != 0 || in_valid || expected_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = KIND_SAMPLE;
    sample = '0;
    now_ms = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_LOUD_THRESHOLD;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // The reset settings are used first: seeding, a streak that grows into a
    // blow, the quiet gap ending it, clear, the unused kind and a time wrap.
    push_item(KIND_RESTART, 10'h000, 32'd0);
    push_item(KIND_SAMPLE, 10'd512, 32'd1);
    push_item(KIND_SAMPLE, 10'h3FF, 32'd2);
    push_item(KIND_SAMPLE, 10'h000, 32'd10);
    push_item(KIND_SAMPLE, 10'h3FF, 32'd50);
    push_item(KIND_SAMPLE, 10'h000, 32'd100);
    push_item(KIND_SAMPLE, 10'h3FF, 32'd150);
    push_item(KIND_SAMPLE, 10'h000, 32'd200);
    push_item(KIND_SAMPLE, 10'h3FF, 32'd250);
    push_item(KIND_SAMPLE, 10'h000, 32'd301);
    push_item(KIND_SAMPLE, 10'h3FF, 32'd302);
    push_item(KIND_UNUSED, 10'h2AA, 32'd400);
    push_item(KIND_SAMPLE, 10'd512, 32'd420);
    push_item(KIND_CLEAR, 10'h155, 32'd430);
    push_item(KIND_SAMPLE, 10'h3FF, 32'hFFFF_FFF0);
    push_item(KIND_SAMPLE, 10'h000, 32'h0000_0100);
    push_item(KIND_SAMPLE, 10'h3FF, 32'h0000_0200);
    push_item(KIND_CLEAR, 10'h3FF, 32'h0000_0210);
    push_item(KIND_RESTART, 10'h3FF, 32'h0000_0300);
    push_item(KIND_SAMPLE, 10'h155, 32'h0000_0301);
    push_item(KIND_SAMPLE, 10'h2AA, 32'h0000_0302);
    push_item(KIND_UNUSED, 10'h3FF, 32'hFFFF_FFFF);
    push_item(KIND_SAMPLE, 10'h000, 32'hFFFF_FFFF);
    push_item(KIND_CLEAR, 10'h000, 32'h0000_0000);
    wait_drained();

    set_config({6'($urandom), 10'($urandom_range(200, 20))}, 16'($urandom_range(200)),
               16'($urandom_range(600)));
    queue_activity(75);
    wait_drained();
    queue_activity(75);
    wait_drained();

    set_config(16'd0, 16'd0, 16'd0);
    queue_activity(100);
    wait_drained();

    write_reg(CFG_RESERVED, 16'($urandom));
    set_config(16'd1023, 16'hFFFF, 16'hFFFF);
    push_item(KIND_RESTART, 10'h000, sim_ms);
    push_item(KIND_SAMPLE, 10'h000, sim_ms + 1);
    push_item(KIND_SAMPLE, 10'h3FF, sim_ms + 2);
    queue_activity(100);
    wait_drained();

    set_config(16'd40, 16'hFFFF, 16'd0);
    queue_activity(80);
    wait_drained();

    no_idle = 1'b1;
    set_config(16'd80, 16'd30, 16'd120);
    queue_activity(150);
    wait_drained();
    no_idle = 1'b0;

    set_config(16'($urandom), 16'($urandom), 16'($urandom));
    queue_activity(100);
    wait_drained();

    repeat (6) @(posedge clk);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
design/mbd_pkg.sv
design/mbd_update.sv
design/mic_blow_detector_unit.sv
dv/tb_mic_blow_detector_unit.sv
